// ----- rtl/core/qrs_pkg.sv -----
// Package for the quadratic root solver: widths, defaults and root-count codes.
package qrs_pkg;

  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROOT_BITS     = 33;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } count_t;

endpackage

// ----- rtl/core/quadratic_root_solver.sv -----
// Quadratic root solver: fully pipelined discriminant, square root and dividers.
//
// Input channel (in_valid/in_ready) takes one word of coefficients a, b, c of
// a*x^2 + b*x + c = 0. Output channel (out_valid/out_ready) returns one word per
// input: root_count (0 none, 1 one, 2 two, 3 infinitely many) and the roots
// first_root, second_root in signed fixed point with FRAC_BITS fraction bits.
// Unused roots read 0; quotients truncate toward zero.
//
// Stages, in order: one multiplier stage, one discriminant stage,
// COEF_BITS+FRAC_BITS+1 square-root stages (one root bit each), one numerator
// stage, COEF_BITS+FRAC_BITS+2 divider stages (one quotient bit each) and the
// output register.
// Throughput is one word per cycle while the receiver does not hold out_ready low.
//
// Reset clears all stage valid bits; no word is in flight afterward.
// When the receiver holds out_ready low with a word waiting, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated.
module quadratic_root_solver #(
  parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COEF_BITS-1:0]         coef_square,
  input  logic signed [COEF_BITS-1:0]         coef_linear,
  input  logic signed [COEF_BITS-1:0]         coef_const,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          root_count,
  output logic signed [qrs_pkg::ROOT_BITS-1:0] first_root,
  output logic signed [qrs_pkg::ROOT_BITS-1:0] second_root
);
  import qrs_pkg::*;

  localparam int CB   = COEF_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2 * CB + 1;
  localparam int SW   = CB + F + 1;
  localparam int RADW = 2 * SW;
  localparam int RMW  = SW + 2;
  localparam int NW   = CB + F + 3;
  localparam int NMW  = CB + F + 2;
  localparam int DVW  = CB + 1;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: products
  logic [CB-1:0] a_mag, b_mag, c_mag;
  assign a_mag = coef_square[CB-1] ? (~$unsigned(coef_square) + CB'(1)) : $unsigned(coef_square);
  assign b_mag = coef_linear[CB-1] ? (~$unsigned(coef_linear) + CB'(1)) : $unsigned(coef_linear);
  assign c_mag = coef_const[CB-1]  ? (~$unsigned(coef_const)  + CB'(1)) : $unsigned(coef_const);

  logic                 v1;
  logic [2*CB-1:0]      p1, q1;
  logic                 ac_pos1;
  logic signed [CB-1:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1      <= a_mag * c_mag;
      q1      <= b_mag * b_mag;
      ac_pos1 <= (coef_square != '0) && (coef_const != '0) &&
                 (coef_square[CB-1] == coef_const[CB-1]);
      a1      <= coef_square;
      b1      <= coef_linear;
      c1      <= coef_const;
    end
  end

  // stage 2: discriminant and root count
  logic [2*CB+1:0] p4, qe, dsum, ddif, dsel;
  logic            dneg;
  count_t          cnt_d;
  assign p4   = {p1, 2'b00};
  assign qe   = {2'b00, q1};
  assign dsum = qe + p4;
  assign ddif = qe - p4;
  assign dneg = ac_pos1 && (p4 > qe);
  assign dsel = ac_pos1 ? ddif : dsum;

  always_comb begin
    if (a1 == '0) begin
      if (b1 == '0) begin
        cnt_d = (c1 == '0) ? CNT_INF : CNT_NONE;
      end else begin
        cnt_d = CNT_ONE;
      end
    end else if (dneg) begin
      cnt_d = CNT_NONE;
    end else if (dsel[DW-1:0] == '0) begin
      cnt_d = CNT_ONE;
    end else begin
      cnt_d = CNT_TWO;
    end
  end

  logic                 v2;
  logic [RADW-1:0]      rad2;
  count_t               cnt2;
  logic signed [CB-1:0] a2, b2, c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad2 <= {1'b0, dsel[DW-1:0], {(2 * F){1'b0}}};
      cnt2 <= cnt_d;
      a2   <= a1;
      b2   <= b1;
      c2   <= c1;
    end
  end

  // square root, one root bit per stage
  logic                 sq_v    [SW];
  logic [RADW-1:0]      sq_rad  [SW];
  logic [RMW-1:0]       sq_rem  [SW];
  logic [SW-1:0]        sq_root [SW];
  count_t               sq_cnt  [SW];
  logic signed [CB-1:0] sq_a    [SW];
  logic signed [CB-1:0] sq_b    [SW];
  logic signed [CB-1:0] sq_c    [SW];

  for (genvar k = 0; k < SW; k++) begin : g_sq
    logic                 v_i;
    logic [RADW-1:0]      rad_i;
    logic [RMW-1:0]       rem_i, rem_sh, trial, rem_n;
    logic [SW-1:0]        root_i;
    count_t               cnt_i;
    logic signed [CB-1:0] a_i, b_i, c_i;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_i    = v2;
      assign rad_i  = rad2;
      assign rem_i  = '0;
      assign root_i = '0;
      assign cnt_i  = cnt2;
      assign a_i    = a2;
      assign b_i    = b2;
      assign c_i    = c2;
    end else begin : g_next
      assign v_i    = sq_v[k-1];
      assign rad_i  = sq_rad[k-1];
      assign rem_i  = sq_rem[k-1];
      assign root_i = sq_root[k-1];
      assign cnt_i  = sq_cnt[k-1];
      assign a_i    = sq_a[k-1];
      assign b_i    = sq_b[k-1];
      assign c_i    = sq_c[k-1];
    end

    assign rem_sh = {rem_i[RMW-3:0], rad_i[RADW-1 -: 2]};
    assign trial  = {root_i, 2'b01};
    assign ge     = rem_sh >= trial;
    assign rem_n  = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (en) begin
        sq_v[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad[k]  <= rad_i << 2;
        sq_rem[k]  <= rem_n;
        sq_root[k] <= {root_i[SW-2:0], ge};
        sq_cnt[k]  <= cnt_i;
        sq_a[k]    <= a_i;
        sq_b[k]    <= b_i;
        sq_c[k]    <= c_i;
      end
    end
  end

  // numerators and divisor as magnitudes with quotient signs
  logic signed [CB-1:0]  a_l, b_l, c_l;
  logic signed [NW-1:0]  b_x, c_x, s_x, nb, num1, num2;
  logic signed [DVW-1:0] den;
  assign a_l  = sq_a[SW-1];
  assign b_l  = sq_b[SW-1];
  assign c_l  = sq_c[SW-1];
  assign b_x  = NW'(b_l);
  assign c_x  = NW'(c_l);
  assign s_x  = $signed(NW'(sq_root[SW-1]));
  assign nb   = -(b_x <<< F);
  assign num1 = (a_l == '0) ? -(c_x <<< F) : (nb - s_x);
  assign num2 = nb + s_x;
  assign den  = (a_l == '0) ? DVW'(b_l) : (DVW'(a_l) <<< 1);

  logic           nv;
  logic [NMW-1:0] n1mag, n2mag;
  logic [DVW-1:0] n_dmag;
  logic           n_q1neg, n_q2neg;
  count_t         n_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= 1'b0;
    end else if (en) begin
      nv <= sq_v[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1mag   <= num1[NW-1] ? NMW'(-num1) : NMW'(num1);
      n2mag   <= num2[NW-1] ? NMW'(-num2) : NMW'(num2);
      n_dmag  <= den[DVW-1] ? DVW'(-den) : DVW'(den);
      n_q1neg <= num1[NW-1] ^ den[DVW-1];
      n_q2neg <= num2[NW-1] ^ den[DVW-1];
      n_cnt   <= sq_cnt[SW-1];
    end
  end

  // two restoring dividers, one quotient bit per stage
  logic           dv_v    [NMW];
  logic [NMW-1:0] dv_nq1  [NMW];
  logic [NMW-1:0] dv_nq2  [NMW];
  logic [DVW-1:0] dv_r1   [NMW];
  logic [DVW-1:0] dv_r2   [NMW];
  logic [DVW-1:0] dv_dm   [NMW];
  logic           dv_neg1 [NMW];
  logic           dv_neg2 [NMW];
  count_t         dv_cnt  [NMW];

  for (genvar j = 0; j < NMW; j++) begin : g_dv
    logic           v_i;
    logic [NMW-1:0] nq1_i, nq2_i;
    logic [DVW-1:0] r1_i, r2_i, dm_i;
    logic           neg1_i, neg2_i;
    count_t         cnt_i;
    logic [DVW:0]   rs1, rs2, df1, df2;
    logic           ge1, ge2;

    if (j == 0) begin : g_first
      assign v_i    = nv;
      assign nq1_i  = n1mag;
      assign nq2_i  = n2mag;
      assign r1_i   = '0;
      assign r2_i   = '0;
      assign dm_i   = n_dmag;
      assign neg1_i = n_q1neg;
      assign neg2_i = n_q2neg;
      assign cnt_i  = n_cnt;
    end else begin : g_next
      assign v_i    = dv_v[j-1];
      assign nq1_i  = dv_nq1[j-1];
      assign nq2_i  = dv_nq2[j-1];
      assign r1_i   = dv_r1[j-1];
      assign r2_i   = dv_r2[j-1];
      assign dm_i   = dv_dm[j-1];
      assign neg1_i = dv_neg1[j-1];
      assign neg2_i = dv_neg2[j-1];
      assign cnt_i  = dv_cnt[j-1];
    end

    assign rs1 = {r1_i, nq1_i[NMW-1]};
    assign rs2 = {r2_i, nq2_i[NMW-1]};
    assign df1 = rs1 - {1'b0, dm_i};
    assign df2 = rs2 - {1'b0, dm_i};
    assign ge1 = rs1 >= {1'b0, dm_i};
    assign ge2 = rs2 >= {1'b0, dm_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (en) begin
        dv_v[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_nq1[j]  <= {nq1_i[NMW-2:0], ge1};
        dv_nq2[j]  <= {nq2_i[NMW-2:0], ge2};
        dv_r1[j]   <= ge1 ? df1[DVW-1:0] : rs1[DVW-1:0];
        dv_r2[j]   <= ge2 ? df2[DVW-1:0] : rs2[DVW-1:0];
        dv_dm[j]   <= dm_i;
        dv_neg1[j] <= neg1_i;
        dv_neg2[j] <= neg2_i;
        dv_cnt[j]  <= cnt_i;
      end
    end
  end

  // output register: apply signs and blank unused roots
  logic signed [NMW:0] qs1, qs2;
  count_t              f_cnt;
  assign f_cnt = dv_cnt[NMW-1];
  assign qs1   = dv_neg1[NMW-1] ? -$signed({1'b0, dv_nq1[NMW-1]})
                                :  $signed({1'b0, dv_nq1[NMW-1]});
  assign qs2   = dv_neg2[NMW-1] ? -$signed({1'b0, dv_nq2[NMW-1]})
                                :  $signed({1'b0, dv_nq2[NMW-1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[NMW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_count  <= f_cnt;
      first_root  <= (f_cnt == CNT_ONE || f_cnt == CNT_TWO) ? ROOT_BITS'(qs1) : '0;
      second_root <= (f_cnt == CNT_TWO) ? ROOT_BITS'(qs2) : '0;
    end
  end

endmodule

// ----- verif/tb_quadratic_root_solver.sv -----
// Testbench for quadratic_root_solver: directed and random equations checked against a predictor.
`timescale 1ns / 100ps

module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int CB = COEF_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] a;
    logic signed [CB-1:0] b;
    logic signed [CB-1:0] c;
  } coefs_t;

  typedef struct packed {
    count_t                      cnt;
    logic signed [ROOT_BITS-1:0] x1;
    logic signed [ROOT_BITS-1:0] x2;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] coef_square = '0;
  logic signed [CB-1:0] coef_linear = '0;
  logic signed [CB-1:0] coef_const = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] root_count;
  logic signed [ROOT_BITS-1:0] first_root;
  logic signed [ROOT_BITS-1:0] second_root;

  coefs_t eqn_q[$];
  roots_t roots_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_solved = 0;
  int cycles = 0;
  int gap_left = 0;
  int burst_left = 4;
  int hold_left = 0;
  bit long_hold_done = 0;
  int stall_mode = 0;
  int cnt_seen[4] = '{0, 0, 0, 0};

  quadratic_root_solver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .coef_square(coef_square), .coef_linear(coef_linear), .coef_const(coef_const),
    .out_valid(out_valid), .out_ready(out_ready),
    .root_count(root_count), .first_root(first_root), .second_root(second_root)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [127:0] root;
    logic [127:0] rem;
    logic [127:0] trial;
    root = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic roots_t solve_eqn(coefs_t e);
    roots_t r;
    longint a, b, c, d, nb, den, s, x1, x2;
    a = e.a;
    b = e.b;
    c = e.c;
    x1 = 0;
    x2 = 0;
    if (a == 0) begin
      if (b == 0) begin
        r.cnt = (c == 0) ? CNT_INF : CNT_NONE;
      end else begin
        r.cnt = CNT_ONE;
        x1 = (-c * (64'sd1 <<< FB)) / b;
      end
    end else begin
      d = b * b - 4 * a * c;
      nb = -b * (64'sd1 <<< FB);
      den = 2 * a;
      if (d < 0) begin
        r.cnt = CNT_NONE;
      end else if (d == 0) begin
        r.cnt = CNT_ONE;
        x1 = nb / den;
      end else begin
        s = longint'(floor_sqrt(128'(d) << (2 * FB)));
        r.cnt = CNT_TWO;
        x1 = (nb - s) / den;
        x2 = (nb + s) / den;
      end
    end
    r.x1 = x1[ROOT_BITS-1:0];
    r.x2 = x2[ROOT_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        roots_q.push_back(solve_eqn('{coef_square, coef_linear, coef_const}));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || eqn_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          coefs_t e;
          e = eqn_q.pop_front();
          coef_square <= e.a;
          coef_linear <= e.b;
          coef_const <= e.c;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (roots_q.size() == 0) begin
          $error("unexpected result word: count %0d", root_count);
          errors++;
        end else begin
          roots_t x;
          x = roots_q.pop_front();
          if (root_count !== x.cnt) begin
            $error("root_count exp %0d got %0d", x.cnt, root_count);
            errors++;
          end
          if (first_root !== x.x1) begin
            $error("first_root exp %0d got %0d", x.x1, first_root);
            errors++;
          end
          if (second_root !== x.x2) begin
            $error("second_root exp %0d got %0d", x.x2, second_root);
            errors++;
          end
          cnt_seen[x.cnt]++;
        end
        n_solved++;
      end
      if (!long_hold_done && n_solved == 300) begin
        long_hold_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout with %0d results outstanding", roots_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic coefs_t rand_eqn();
    coefs_t e;
    int k;
    int sel;
    e.a = CB'($urandom);
    e.b = CB'($urandom);
    e.c = CB'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      e.a = '0;
    end else if (sel < 15) begin
      e.a = '0;
      e.b = '0;
      if ($urandom_range(0, 1)) e.c = '0;
    end else if (sel < 27) begin
      e.a = CB'($signed(5'($urandom)));
      e.b = CB'($signed(7'($urandom)));
      e.c = CB'($signed(5'($urandom)));
    end else if (sel < 35) begin
      k = $urandom_range(0, 181);
      e.a = CB'(1);
      e.b = CB'(2 * k);
      e.c = CB'(k * k);
      if ($urandom_range(0, 1)) begin
        e.a = CB'(-1);
        e.c = CB'(-k * k);
      end
    end
    return e;
  endfunction

  task automatic drain();
    wait (eqn_q.size() == 0 && !in_valid && roots_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    coefs_t e;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    eqn_q.push_back('{16'sd0, 16'sd0, 16'sd0});
    eqn_q.push_back('{16'sd0, 16'sd0, 16'sd5});
    eqn_q.push_back('{16'sd0, 16'sd0, -16'sd32768});
    eqn_q.push_back('{16'sd0, 16'sd3, 16'sd7});
    eqn_q.push_back('{16'sd0, -16'sd32768, 16'sd32767});
    eqn_q.push_back('{16'sd0, 16'sd1, -16'sd32768});
    eqn_q.push_back('{16'sd0, -16'sd1, 16'sd32767});
    eqn_q.push_back('{16'sd1, 16'sd0, 16'sd1});
    eqn_q.push_back('{16'sd32767, 16'sd0, 16'sd32767});
    eqn_q.push_back('{16'sd1, 16'sd2, 16'sd1});
    eqn_q.push_back('{-16'sd32768, -16'sd32768, -16'sd8192});
    eqn_q.push_back('{16'sd1, -16'sd3, 16'sd2});
    eqn_q.push_back('{16'sd1, 16'sd0, -16'sd1});
    eqn_q.push_back('{-16'sd32768, 16'sd32767, 16'sd32767});
    eqn_q.push_back('{16'sd32767, -16'sd32768, -16'sd32768});
    eqn_q.push_back('{-16'sd32768, -16'sd32768, 16'sd32767});
    eqn_q.push_back('{16'sd1, -16'sd32768, -16'sd32768});
    eqn_q.push_back('{16'sd1, 16'sd32767, 16'sd0});
    eqn_q.push_back('{-16'sd1, 16'sd0, 16'sd0});
    eqn_q.push_back('{16'sd32767, 16'sd32767, -16'sd1});
    drain();
    for (int i = 0; i < 1630; i++) begin
      e = rand_eqn();
      eqn_q.push_back(e);
      if (i == 800) begin
        wait (eqn_q.size() == 0);
        drain();
      end
    end
    drain();
    repeat (100) @(posedge clk);
    $display("%0d equations solved: %0d none, %0d one, %0d two, %0d infinite roots",
             n_solved, cnt_seen[0], cnt_seen[1], cnt_seen[2], cnt_seen[3]);
    if (errors == 0 && roots_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/qrs_pkg.sv
rtl/core/quadratic_root_solver.sv
verif/tb_quadratic_root_solver.sv
